// ===== rtl/aabb_pkg.sv =====
// Shared constants and types for the box overlap side classifier.
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int COORD_BITS   = 16;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int CFG_IDX_BITS = 2;
    localparam int SIDE_BITS    = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOX_LEFT   = 2'd0,
        REG_BOX_TOP    = 2'd1,
        REG_BOX_RIGHT  = 2'd2,
        REG_BOX_BOTTOM = 2'd3
    } cfg_reg_t;

    typedef enum logic [SIDE_BITS-1:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_BOTTOM = 3'd4
    } side_t;

endpackage

// ===== rtl/aabb_overlap_side_classifier_unit.sv =====
// Top level of the box overlap and minimum penetration side classifier.
//
// Usage:
//   The reference box sits in four registers written through cfg_we,
//   cfg_index and cfg_wdata (0 left, 1 top, 2 right, 3 bottom). Write them
//   only while no transaction is in flight.
//   Each s_ transaction carries one tested box; each m_ transaction returns
//   m_overlap and m_contact_side (0 none or tie, 1 left, 2 right, 3 top,
//   4 bottom) for that box, in order.
//   Four register stages lie between input acceptance and the result on m_:
//   difference, depth select, cross multiply and compare; one transaction is
//   taken per cycle, limited only by the receiver.
//   A stall on m_ready holds the result and backs up the stages one by
//   one; s_ready drops only when every stage holds a transaction.
//   Reset (aresetn low at a clock edge) clears the box registers to zero
//   and empties the pipeline.
`timescale 1ns / 1ps

module aabb_overlap_side_classifier_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [aabb_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [aabb_pkg::COORD_BITS-1:0]         cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  s_other_left,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  s_other_top,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  s_other_right,
    input  logic signed [aabb_pkg::COORD_BITS-1:0]  s_other_bottom,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_overlap,
    output logic [aabb_pkg::SIDE_BITS-1:0]          m_contact_side
);
    import aabb_pkg::*;

    logic signed [COORD_BITS-1:0] box_left_reg, box_top_reg, box_right_reg, box_bottom_reg;

    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic en1, en2, en3, en4;

    logic                        ov1_reg;
    logic signed [DIFF_BITS-1:0] w1_reg, h1_reg, dl1_reg, dr1_reg, du1_reg, dd1_reg;
    logic signed [DIFF_BITS-1:0] dl_next, dr_next, du_next, dd_next, w_next, h_next;
    logic                        ov_next;

    logic                        ov2_reg;
    logic signed [DIFF_BITS-1:0] xd2_reg, yd2_reg, w2_reg, h2_reg;
    side_t                       xs2_reg, ys2_reg;

    logic                        ov3_reg;
    logic signed [PROD_BITS-1:0] px3_reg, py3_reg;
    side_t                       xs3_reg, ys3_reg;

    logic                        m_overlap_reg;
    side_t                       m_side_reg, side_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BOX_LEFT:   box_left_reg   <= cfg_wdata;
                REG_BOX_TOP:    box_top_reg    <= cfg_wdata;
                REG_BOX_RIGHT:  box_right_reg  <= cfg_wdata;
                REG_BOX_BOTTOM: box_bottom_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage enables: advance when the next stage is empty or advancing
    assign en4     = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg      <= s_valid;
            if (en2) v2_reg      <= v1_reg;
            if (en3) v3_reg      <= v2_reg;
            if (en4) m_valid_reg <= v3_reg;
        end
    end

    // stage 1: overlap test and differences
    always_comb begin
        ov_next = (box_left_reg < s_other_right) && (box_top_reg < s_other_bottom) &&
                  (box_right_reg > s_other_left) && (box_bottom_reg > s_other_top);
        w_next  = DIFF_BITS'(s_other_right)  - DIFF_BITS'(s_other_left);
        h_next  = DIFF_BITS'(s_other_bottom) - DIFF_BITS'(s_other_top);
        dr_next = DIFF_BITS'(box_right_reg)  - DIFF_BITS'(s_other_left);
        dl_next = DIFF_BITS'(s_other_right)  - DIFF_BITS'(box_left_reg);
        dd_next = DIFF_BITS'(box_bottom_reg) - DIFF_BITS'(s_other_top);
        du_next = DIFF_BITS'(s_other_bottom) - DIFF_BITS'(box_top_reg);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            ov1_reg <= ov_next;
            w1_reg  <= w_next;
            h1_reg  <= h_next;
            dl1_reg <= dl_next;
            dr1_reg <= dr_next;
            du1_reg <= du_next;
            dd1_reg <= dd_next;
        end
    end

    // stage 2: pick the shallower side on each axis
    always_ff @(posedge aclk) begin
        if (en2) begin
            ov2_reg <= ov1_reg;
            w2_reg  <= w1_reg;
            h2_reg  <= h1_reg;
            if (dl1_reg < dr1_reg) begin
                xs2_reg <= SIDE_LEFT;
                xd2_reg <= dl1_reg;
            end else begin
                xs2_reg <= SIDE_RIGHT;
                xd2_reg <= dr1_reg;
            end
            if (du1_reg < dd1_reg) begin
                ys2_reg <= SIDE_TOP;
                yd2_reg <= du1_reg;
            end else begin
                ys2_reg <= SIDE_BOTTOM;
                yd2_reg <= dd1_reg;
            end
        end
    end

    // stage 3: cross multiply
    always_ff @(posedge aclk) begin
        if (en3) begin
            ov3_reg <= ov2_reg;
            xs3_reg <= xs2_reg;
            ys3_reg <= ys2_reg;
            px3_reg <= PROD_BITS'(xd2_reg) * PROD_BITS'(h2_reg);
            py3_reg <= PROD_BITS'(yd2_reg) * PROD_BITS'(w2_reg);
        end
    end

    // stage 4: compare and classify
    always_comb begin
        priority if (!ov3_reg) begin
            side_next = SIDE_NONE;
        end else if (px3_reg < py3_reg) begin
            side_next = xs3_reg;
        end else if (px3_reg > py3_reg) begin
            side_next = ys3_reg;
        end else begin
            side_next = SIDE_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            m_overlap_reg <= ov3_reg;
            m_side_reg    <= side_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_overlap      = m_overlap_reg;
    assign m_contact_side = m_side_reg;

`ifndef SYNTH
    a_no_overlap_no_side: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_overlap) |-> (m_contact_side == SIDE_NONE))
        else $error("side reported without overlap");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted transaction missing from first stage");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && en4) |=> m_valid)
        else $error("transaction lost between multiply and output stages");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !v1_reg && !v2_reg && !v3_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule
